[rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Transfer types, operation and status codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int KEY_W     = 24;
    localparam int PAYLOAD_W = 16;
    localparam int COUNT_W   = 8;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_POP    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]           kind;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } t_in;

    typedef struct packed {
        logic [1:0]           status;
        logic [KEY_W-1:0]     out_key;
        logic [PAYLOAD_W-1:0] out_payload;
        logic [COUNT_W-1:0]   count;
    } t_out;

    // Controller to datapath.
    typedef struct packed {
        logic       load;        // take the incoming entry into the carry register
        logic       load_tail;   // start the walk at the tail instead of the head
        logic       rd_idx;      // read the entry at the walk position
        logic       rd_head;     // read the head entry
        logic       step;        // advance the walk without writing
        logic       swap;        // write carry at walk position, carry takes read data
        logic       wr_tail;     // write carry at walk position and grow the list
        logic       pop_commit;  // drop the head entry
        logic       res_load;    // fill the result register
        logic [1:0] res_status;
        logic       res_pop;     // result carries the popped entry
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic idx_end;
        logic key_ge;
    } t_sts;

endpackage

[rtl/spq_ctrl.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Sequences one operation at a time: the walk over the list for append and
// ordered insert, the head read for pop, and the hand-off of the result.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_in_kind,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  spq_pkg::t_sts i_sts,
    output spq_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CMP,
        S_POP,
        S_RES
    } t_state;

    t_state     r_state, n_state;
    logic       r_found, n_found;
    logic       r_pop, n_pop;
    logic [1:0] r_status, n_status;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_found     = r_found;
        n_pop       = r_pop;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_found    = 1'b0;
                    n_pop      = 1'b0;
                    n_status   = spq_pkg::ST_OK;
                    case (i_in_kind)
                        spq_pkg::KIND_APPEND,
                        spq_pkg::KIND_INSERT: begin
                            o_cmd.load_tail = (i_in_kind == spq_pkg::KIND_APPEND);
                            if (i_sts.full) begin
                                n_status = spq_pkg::ST_FULL;
                                n_state  = S_RES;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        spq_pkg::KIND_POP: begin
                            if (i_sts.empty) begin
                                n_status = spq_pkg::ST_EMPTY;
                                n_state  = S_RES;
                            end else begin
                                n_state = S_POP;
                            end
                        end
                        default: begin
                            n_state = S_RES;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (i_sts.idx_end) begin
                    o_cmd.wr_tail = 1'b1;
                    n_state       = S_RES;
                end else begin
                    o_cmd.rd_idx = 1'b1;
                    n_state      = S_CMP;
                end
            end
            S_CMP: begin
                // Once the insert point is found, every later entry moves up one.
                if (r_found || i_sts.key_ge) begin
                    o_cmd.swap = 1'b1;
                    n_found    = 1'b1;
                end else begin
                    o_cmd.step = 1'b1;
                end
                n_state = S_SCAN;
            end
            S_POP: begin
                o_cmd.rd_head    = 1'b1;
                o_cmd.pop_commit = 1'b1;
                n_pop            = 1'b1;
                n_state          = S_RES;
            end
            S_RES: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = r_status;
                    o_cmd.res_pop    = r_pop;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_found     <= 1'b0;
            r_pop       <= 1'b0;
            r_status    <= spq_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_found     <= n_found;
            r_pop       <= n_pop;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[rtl/spq_dpath.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// Entry memory kept as a ring from a head pointer, the walk position, the
// carry register that ripples entries toward the tail, and the result register.
// ----------------------------------------------------------------------------
module spq_dpath #(
    parameter int CAPACITY     = 128,
    parameter int KEY_BITS     = 24,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  spq_pkg::t_in  i_in,
    input  spq_pkg::t_cmd i_cmd,
    output spq_pkg::t_sts o_sts,
    output spq_pkg::t_out o_out
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = AW + 1;
    localparam int EW = KEY_BITS + PAYLOAD_BITS;

    logic [EW-1:0]  mem [CAPACITY];
    logic [AW-1:0]  r_head;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_idx;
    logic [EW-1:0]  r_carry;
    logic [EW-1:0]  r_rd;
    spq_pkg::t_out  r_res;

    logic [SW-1:0]  sum;
    logic [AW-1:0]  idx_addr;
    logic [AW-1:0]  rd_addr;
    logic [KEY_BITS-1:0]     rd_key;
    logic [KEY_BITS-1:0]     carry_key;
    logic [PAYLOAD_BITS-1:0] rd_payload;

    // Ring position of the walk index; head plus index stays below twice the depth.
    always_comb begin
        sum = SW'(r_head) + SW'(r_idx);
        if (sum >= SW'(CAPACITY)) begin
            idx_addr = AW'(sum - SW'(CAPACITY));
        end else begin
            idx_addr = AW'(sum);
        end
    end

    assign rd_addr    = i_cmd.rd_head ? r_head : idx_addr;
    assign rd_key     = r_rd[EW-1:PAYLOAD_BITS];
    assign rd_payload = r_rd[PAYLOAD_BITS-1:0];
    assign carry_key  = r_carry[EW-1:PAYLOAD_BITS];

    always_ff @(posedge i_clk) begin
        if (i_cmd.swap || i_cmd.wr_tail) begin
            mem[idx_addr] <= r_carry;
        end
        if (i_cmd.rd_idx || i_cmd.rd_head) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_carry <= {KEY_BITS'(i_in.key), PAYLOAD_BITS'(i_in.payload)};
            r_idx   <= i_cmd.load_tail ? r_count : '0;
        end else if (i_cmd.swap) begin
            r_carry <= r_rd;
            r_idx   <= r_idx + CW'(1);
        end else if (i_cmd.step) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.res_load) begin
            r_res.status      <= i_cmd.res_status;
            r_res.out_key     <= i_cmd.res_pop ? spq_pkg::KEY_W'(rd_key) : '0;
            r_res.out_payload <= i_cmd.res_pop ? spq_pkg::PAYLOAD_W'(rd_payload) : '0;
            r_res.count       <= spq_pkg::COUNT_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.wr_tail) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop_commit) begin
                r_count <= r_count - CW'(1);
                if (r_head == AW'(CAPACITY - 1)) begin
                    r_head <= '0;
                end else begin
                    r_head <= r_head + AW'(1);
                end
            end
        end
    end

    assign o_sts.full    = (r_count == CW'(CAPACITY));
    assign o_sts.empty   = (r_count == '0);
    assign o_sts.idx_end = (r_idx == r_count);
    assign o_sts.key_ge  = (rd_key >= carry_key);
    assign o_out         = r_res;

endmodule

[rtl/sorted_priority_queue_core.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue core
// Ordered list of key and payload entries with append, ordered insert and pop.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_in_valid, i_in, o_in_stall) carries one operation per
//   transfer: append at the tail, ordered insert ahead of the first entry with
//   a key greater than or equal to the new key, or pop of the head. Each
//   operation returns exactly one result on the output channel (o_out_valid,
//   o_out, i_out_stall) with status, popped entry and the count afterwards.
//   One operation is worked on at a time; o_in_stall is high until it is done.
//   Append writes at the tail at once; ordered insert walks the list from the
//   head, each entry held taking a read and then a compare with a write or a
//   step, on the single read port and write port. Rejected pushes, pops on an
//   empty queue and unused codes go straight to the result. The next operation
//   can be taken in the same cycle that the result turns valid.
//   The result sits in an output register, so a new operation is taken while
//   a result waits; if the receiver stalls, the next result waits for the
//   register to empty and its operation holds the input side stalled.
//   Reset empties the queue and clears the output valid; memory contents are
//   left as they are since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
    parameter int CAPACITY     = 128,
    parameter int KEY_BITS     = 24,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  spq_pkg::t_in  i_in,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output spq_pkg::t_out o_out,
    input  logic          i_out_stall
);

    spq_pkg::t_cmd cmd;
    spq_pkg::t_sts sts;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_kind   (i_in.kind),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    spq_dpath #(
        .CAPACITY     (CAPACITY),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_out   (o_out)
    );

endmodule

[rtl/spq_chk.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue port checker
// Watches the ports of the core over time and flags inconsistent results.
// ----------------------------------------------------------------------------
module spq_chk #(
    parameter int CAPACITY = 128
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input spq_pkg::t_out o_out,
    input logic          i_out_stall
);

    // A stalled result holds until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    // One operation at a time: the input side stalls right after a transfer.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an operation is in progress");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == spq_pkg::ST_EMPTY) |->
            (o_out.count == '0) && (o_out.out_key == '0) && (o_out.out_payload == '0))
        else $error("pop on empty queue reported data or a count");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == spq_pkg::ST_FULL) |->
            (o_out.count == spq_pkg::COUNT_W'(CAPACITY)) && (o_out.out_key == '0)
            && (o_out.out_payload == '0))
        else $error("rejected push reported data or a wrong count");

endmodule

bind sorted_priority_queue_core spq_chk #(.CAPACITY(CAPACITY)) u_spq_chk (.*);

[sim/sorted_priority_queue_core_tb.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue core testbench
// Drives append, ordered insert, pop and unused operation codes through the
// valid/stall input channel and checks every result against a queue model
// kept in the testbench. A short directed table comes first, then random
// phases that fill the queue to capacity, drain it past empty, or mix both.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core_tb;

    localparam int          DEPTH       = 128;
    localparam int          N_RANDOM    = 1600;
    localparam int          CYCLE_LIMIT = 3000000;
    localparam int          DRAIN_WAIT  = 20;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [spq_pkg::KEY_W-1:0]     key;
        logic [spq_pkg::PAYLOAD_W-1:0] payload;
    } t_entry;

    typedef struct packed {
        spq_pkg::t_in  op;
        logic          typed;
        spq_pkg::t_out res;
    } t_row;

    typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_MIXED} t_phase;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    spq_pkg::t_in  in_data   = '0;
    logic          in_stall;
    logic          out_valid;
    spq_pkg::t_out out_data;
    logic          out_stall = 1'b0;

    logic in_gaps_on  = 1'b1;
    logic out_gaps_on = 1'b1;

    t_entry        held_entries[$];
    spq_pkg::t_out expected_results[$];
    logic [1:0]    last_status;

    int err_count    = 0;
    int results_seen = 0;
    int cycle_count  = 0;
    int n_append = 0, n_insert = 0, n_pop = 0, n_unused = 0;
    int n_full_rej = 0, n_empty_pop = 0, n_full_hits = 0;

    // Rows with the typed flag set carry a result that is known without the model.
    t_row directed_rows [0:22] = '{
        '{'{spq_pkg::KIND_POP, 24'h000000, 16'h0000}, 1'b1,
          '{spq_pkg::ST_EMPTY, 24'h0, 16'h0, 8'd0}},
        '{'{KIND_UNUSED, 24'hffffff, 16'hffff}, 1'b1,
          '{spq_pkg::ST_OK, 24'h0, 16'h0, 8'd0}},
        '{'{spq_pkg::KIND_INSERT, 24'hffffff, 16'hffff}, 1'b1,
          '{spq_pkg::ST_OK, 24'h0, 16'h0, 8'd1}},
        '{'{spq_pkg::KIND_APPEND, 24'h000000, 16'h0000}, 1'b1,
          '{spq_pkg::ST_OK, 24'h0, 16'h0, 8'd2}},
        '{'{spq_pkg::KIND_INSERT, 24'h800000, 16'h1234}, 1'b0, '0},
        '{'{spq_pkg::KIND_INSERT, 24'h800000, 16'h5678}, 1'b0, '0},
        '{'{spq_pkg::KIND_APPEND, 24'h000001, 16'h0001}, 1'b0, '0},
        '{'{spq_pkg::KIND_INSERT, 24'h000000, 16'haaaa}, 1'b0, '0},
        '{'{KIND_UNUSED,          24'h123456, 16'h4321}, 1'b0, '0},
        '{'{spq_pkg::KIND_POP,    24'h000000, 16'h0000}, 1'b0, '0},
        '{'{spq_pkg::KIND_POP,    24'hffffff, 16'hffff}, 1'b0, '0},
        '{'{spq_pkg::KIND_POP,    24'h000000, 16'h0000}, 1'b0, '0},
        '{'{spq_pkg::KIND_POP,    24'h000000, 16'h0000}, 1'b0, '0},
        '{'{spq_pkg::KIND_POP,    24'h000000, 16'h0000}, 1'b0, '0},
        '{'{spq_pkg::KIND_POP,    24'h000000, 16'h0000}, 1'b0, '0},
        '{'{spq_pkg::KIND_POP, 24'h000000, 16'h0000}, 1'b1,
          '{spq_pkg::ST_EMPTY, 24'h0, 16'h0, 8'd0}},
        '{'{spq_pkg::KIND_INSERT, 24'h555555, 16'h5555}, 1'b0, '0},
        '{'{spq_pkg::KIND_APPEND, 24'haaaaaa, 16'haaaa}, 1'b0, '0},
        '{'{spq_pkg::KIND_INSERT, 24'h7fffff, 16'h8000}, 1'b0, '0},
        '{'{spq_pkg::KIND_POP,    24'h000000, 16'h0000}, 1'b0, '0},
        '{'{spq_pkg::KIND_POP,    24'h000000, 16'h0000}, 1'b0, '0},
        '{'{spq_pkg::KIND_POP,    24'h000000, 16'h0000}, 1'b0, '0},
        '{'{spq_pkg::KIND_POP, 24'h000000, 16'h0000}, 1'b1,
          '{spq_pkg::ST_EMPTY, 24'h0, 16'h0, 8'd0}}
    };

    sorted_priority_queue_core #(
        .CAPACITY(DEPTH)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in       (in_data),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out      (out_data),
        .i_out_stall(out_stall)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Applies one operation to the model list and returns the result it gives.
    function automatic spq_pkg::t_out apply_queue_op(input spq_pkg::t_in op);
        spq_pkg::t_out res;
        t_entry        e;
        int            pos;
        res = '0;
        e.key = op.key;
        e.payload = op.payload;
        if (op.kind == spq_pkg::KIND_APPEND || op.kind == spq_pkg::KIND_INSERT) begin
            if (held_entries.size() >= DEPTH) begin
                res.status = spq_pkg::ST_FULL;
                n_full_rej++;
            end else if (op.kind == spq_pkg::KIND_APPEND) begin
                held_entries.push_back(e);
                n_append++;
            end else begin
                pos = 0;
                while (pos < held_entries.size() && held_entries[pos].key < op.key)
                    pos++;
                held_entries.insert(pos, e);
                n_insert++;
            end
            if (res.status == spq_pkg::ST_OK && held_entries.size() == DEPTH)
                n_full_hits++;
        end else if (op.kind == spq_pkg::KIND_POP) begin
            if (held_entries.size() == 0) begin
                res.status = spq_pkg::ST_EMPTY;
                n_empty_pop++;
            end else begin
                e = held_entries.pop_front();
                res.out_key = e.key;
                res.out_payload = e.payload;
                n_pop++;
            end
        end else begin
            n_unused++;
        end
        res.count = spq_pkg::COUNT_W'(held_entries.size());
        return res;
    endfunction

    function automatic logic [spq_pkg::KEY_W-1:0] pick_key(input int style);
        logic [spq_pkg::KEY_W-1:0] k;
        case (style)
            0: k = spq_pkg::KEY_W'($urandom_range(0, 15));
            1: k = spq_pkg::KEY_W'($urandom);
            2: begin
                case ($urandom_range(0, 3))
                    0:       k = '0;
                    1:       k = '1;
                    2:       k = spq_pkg::KEY_W'(1);
                    default: k = {{(spq_pkg::KEY_W-1){1'b1}}, 1'b0};
                endcase
            end
            default: k = spq_pkg::KEY_W'($urandom_range(0, 255));
        endcase
        return k;
    endfunction

    task automatic send_op(input spq_pkg::t_in op, input logic typed,
                           input spq_pkg::t_out typed_res);
        spq_pkg::t_out res;
        while (in_gaps_on && $urandom_range(0, 99) < 30) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= op;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = apply_queue_op(op);
        last_status = res.status;
        expected_results.push_back(typed ? typed_res : res);
    endtask

    task automatic compare_result(input spq_pkg::t_out want, input spq_pkg::t_out got);
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            err_count++;
        end
        if (got.out_key !== want.out_key) begin
            $error("out_key: expected 0x%06h, got 0x%06h", want.out_key, got.out_key);
            err_count++;
        end
        if (got.out_payload !== want.out_payload) begin
            $error("out_payload: expected 0x%04h, got 0x%04h",
                   want.out_payload, got.out_payload);
            err_count++;
        end
        if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            err_count++;
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= out_gaps_on && ($urandom_range(0, 99) < 30);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected: status %0d count %0d",
                       out_data.status, out_data.count);
                err_count++;
            end else begin
                compare_result(expected_results.pop_front(), out_data);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        spq_pkg::t_in op;
        t_phase       mode;
        int           ops_sent;
        int           left;
        int           extra;
        int           key_style;
        int           roll;
        logic         want_push;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_op(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].res);

        ops_sent = 0;
        while (ops_sent < N_RANDOM) begin
            mode      = t_phase'($urandom_range(0, 2));
            key_style = $urandom_range(0, 3);
            left      = (mode == PH_MIXED) ? $urandom_range(30, 120) : 400;
            extra     = $urandom_range(1, 4);
            while (left > 0 && extra > 0 && ops_sent < N_RANDOM) begin
                // A quiet stretch with no gaps on either side.
                in_gaps_on  = !(ops_sent >= 700 && ops_sent < 1000);
                out_gaps_on = in_gaps_on;
                roll = $urandom_range(0, 99);
                case (mode)
                    PH_FILL:  want_push = (roll < 90);
                    PH_DRAIN: want_push = (roll < 10);
                    default:  want_push = (roll < 50);
                endcase
                op.key     = pick_key(key_style);
                op.payload = spq_pkg::PAYLOAD_W'($urandom);
                if ($urandom_range(0, 99) < 3)
                    op.kind = KIND_UNUSED;
                else if (want_push)
                    op.kind = $urandom_range(0, 1) ? spq_pkg::KIND_INSERT
                                                   : spq_pkg::KIND_APPEND;
                else
                    op.kind = spq_pkg::KIND_POP;
                send_op(op, 1'b0, '0);
                if (op.kind != KIND_UNUSED)
                    ops_sent++;
                left--;
                // Fill and drain phases end a few operations past the boundary.
                if ((mode == PH_FILL && last_status == spq_pkg::ST_FULL) ||
                    (mode == PH_DRAIN && last_status == spq_pkg::ST_EMPTY))
                    extra--;
            end
        end

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d appends, %0d ordered inserts, %0d pops and %0d unused codes.",
                 n_append, n_insert, n_pop, n_unused);
        $display("Queue filled %0d times; %0d pushes rejected, %0d empty pops; %0d results.",
                 n_full_hits, n_full_rej, n_empty_pop, results_seen);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_dpath.sv
rtl/sorted_priority_queue_core.sv
rtl/spq_chk.sv
sim/sorted_priority_queue_core_tb.sv
